>>> rtl/sild_pkg.sv
// Shared types and constants for the stream id / length deframer.
// No dependencies; imported by the core, the parser and the output register.
package sild_pkg;

  // Header layout: 32-bit stream id then 32-bit payload length, big-endian
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned ID_BYTES    = 4;
  localparam int unsigned CNT_W       = $clog2(HDR_BYTES);
  localparam int unsigned SHIFT_W     = (HDR_BYTES - 1) * 8;
  localparam int unsigned SID_W       = ID_BYTES * 8;
  localparam int unsigned LEN_W       = (HDR_BYTES - ID_BYTES) * 8;
  localparam logic [CNT_W-1:0] LAST_HDR_IDX = CNT_W'(HDR_BYTES - 1);

  // One result item as it travels from the parser to the output register
  typedef struct packed {
    logic [SID_W-1:0] stream_id;
    logic [7:0]       payload_byte;
    logic             last;
    logic             empty_res;
  } sild_res_t;

endpackage

>>> rtl/stream_id_length_deframer_core.sv
// Length-prefixed frame deframer. Takes one transport byte per transfer and
// splits the stream into frames of an 8-byte big-endian header (32-bit stream
// id, 32-bit length) and payload. Every payload byte comes out tagged with its
// stream id, the final one marked last; a zero-length frame gives one result
// marked empty. No resync: any 8 bytes are taken as a header. Throughput is one
// byte per cycle while out_ready stays high; a byte's result passes the input
// register and then the output register around the combinational parser, and
// waits in the output register until out_ready takes it.
// Depends on sild_pkg, sild_in_reg, sild_parse and sild_out_reg.
module stream_id_length_deframer_core
  import sild_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SID_W-1:0] out_stream_id,
  output logic [7:0]       out_payload_byte,
  output logic             out_last,
  output logic             out_empty_res
);

  logic      q_valid;
  logic [7:0] q_byte;
  logic      step;
  logic      room;
  logic      res_valid;
  sild_res_t res;
  sild_res_t out_res;

  // Parse a held byte whenever the output register can take its result
  assign step = q_valid && room;

  sild_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_byte       (q_byte),
    .q_take       (step)
  );

  sild_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (q_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sild_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_valid   (res_valid),
    .d_res     (res),
    .d_room    (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q_res     (out_res)
  );

  assign out_stream_id    = out_res.stream_id;
  assign out_payload_byte = out_res.payload_byte;
  assign out_last         = out_res.last;
  assign out_empty_res    = out_res.empty_res;

endmodule

>>> rtl/sild_in_reg.sv
// Input register stage of the deframer: captures one transport byte per transfer.
// No package dependencies; instantiated by stream_id_length_deframer_core.
module sild_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       q_take
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready = !valid_r || q_take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (q_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_data_byte;
    end
  end

  assign q_valid = valid_r;
  assign q_byte  = byte_r;

endmodule

>>> rtl/sild_parse.sv
// Frame parser: header collection, payload countdown and result forming.
// Depends on sild_pkg for header layout constants and the result struct.
module sild_parse
  import sild_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output sild_res_t  res
);

  logic               in_payload_r, in_payload_nxt;
  logic [CNT_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [SHIFT_W-1:0] hdr_shift_r, hdr_shift_nxt;
  logic [LEN_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [SID_W-1:0]   cur_sid_r, cur_sid_nxt;
  logic [SID_W-1:0]   hdr_sid;
  logic [LEN_W-1:0]   hdr_len;
  logic [LEN_W-1:0]   left_dec;

  // Header fields as seen with the eighth byte joined in
  assign hdr_sid  = hdr_shift_r[SHIFT_W-1 -: SID_W];
  assign hdr_len  = {hdr_shift_r[LEN_W-9:0], data_byte};
  assign left_dec = (bytes_left_r != '0) ? bytes_left_r - LEN_W'(1) : bytes_left_r;

  // Advance state and form the result for one byte
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_shift_nxt  = hdr_shift_r;
    bytes_left_nxt = bytes_left_r;
    cur_sid_nxt    = cur_sid_r;
    res_valid      = 1'b0;
    res            = '0;
    if (step) begin
      if (in_payload_r) begin
        res_valid        = 1'b1;
        res.stream_id    = cur_sid_r;
        res.payload_byte = data_byte;
        res.last         = (bytes_left_r <= LEN_W'(1));
        bytes_left_nxt   = left_dec;
        if (left_dec == '0) begin
          in_payload_nxt = 1'b0;
          hdr_cnt_nxt    = '0;
        end
      end else if (hdr_cnt_r == LAST_HDR_IDX) begin
        hdr_cnt_nxt = '0;
        cur_sid_nxt = hdr_sid;
        if (hdr_len == '0) begin
          res_valid     = 1'b1;
          res.stream_id = hdr_sid;
          res.last      = 1'b1;
          res.empty_res = 1'b1;
        end else begin
          bytes_left_nxt = hdr_len;
          in_payload_nxt = 1'b1;
        end
      end else begin
        hdr_shift_nxt = {hdr_shift_r[SHIFT_W-9:0], data_byte};
        hdr_cnt_nxt   = hdr_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      bytes_left_r <= '0;
      cur_sid_r    <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      cur_sid_r    <= cur_sid_nxt;
    end
  end

  // Header bytes are fully overwritten before use; no reset needed
  always_ff @(posedge clk) begin
    hdr_shift_r <= hdr_shift_nxt;
  end

endmodule

>>> rtl/sild_out_reg.sv
// Output register of the deframer: holds one result until its transfer.
// Depends on sild_pkg for the result struct.
module sild_out_reg
  import sild_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      d_valid,
  input  sild_res_t d_res,
  output logic      d_room,
  output logic      out_valid,
  input  logic      out_ready,
  output sild_res_t q_res
);

  logic      valid_r, valid_nxt;
  sild_res_t res_r;

  // Room when empty or when the held result transfers this cycle
  assign d_room = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (d_room) begin
      valid_nxt = d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (d_room && d_valid) begin
      res_r <= d_res;
    end
  end

  assign out_valid = valid_r;
  assign q_res     = res_r;

endmodule
